@@ hw/rtl/quad_code_executor_top_defines.svh @@
// Assertion macros shared by the quad code executor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef QUAD_CODE_EXECUTOR_TOP_DEFINES_SVH
`define QUAD_CODE_EXECUTOR_TOP_DEFINES_SVH

// Asserts that an implication holds at every clock edge outside reset.
`define QCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Asserts that an implication holds in the cycle after the antecedent, outside reset.
`define QCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/qce_pkg.sv @@
// Package of the quad code executor: widths, codes and shared types.
// Depends on nothing.
`default_nettype none
package qce_pkg;
   localparam int VariableCount  = 64;
   localparam int TemporaryCount = 64;
   localparam int ProgramDepth   = 1024;
   localparam int RegIdxW = 6;
   localparam int PcW     = 11;
   localparam int ValW    = 64;

   localparam logic [3:0] MODE_MOV  = 4'd0;
   localparam logic [3:0] MODE_ADD  = 4'd1;
   localparam logic [3:0] MODE_SUB  = 4'd2;
   localparam logic [3:0] MODE_MUL  = 4'd3;
   localparam logic [3:0] MODE_DIV  = 4'd4;
   localparam logic [3:0] MODE_JEQ  = 4'd5;
   localparam logic [3:0] MODE_JNEQ = 4'd6;
   localparam logic [3:0] MODE_JGT  = 4'd7;
   localparam logic [3:0] MODE_JGTE = 4'd8;
   localparam logic [3:0] MODE_JLT  = 4'd9;
   localparam logic [3:0] MODE_JLTE = 4'd10;
   localparam logic [3:0] MODE_J    = 4'd11;

   localparam logic [1:0] KIND_VAR = 2'd0;
   localparam logic [1:0] KIND_TMP = 2'd1;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_LIT    = 3'd1;
   localparam logic [2:0] ST_DIVZ   = 3'd2;
   localparam logic [2:0] ST_OVF    = 3'd3;
   localparam logic [2:0] ST_HALTED = 3'd4;

   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

   // Operation requested of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic ovf;
   } alu_stat_type;
endpackage
`default_nettype wire

@@ hw/rtl/qce_alu.sv @@
// Shared sequential multiply/divide unit on Q32.32 magnitudes.
// Depends on qce_pkg and the assertion macros header.
`default_nettype none
`include "quad_code_executor_top_defines.svh"
module qce_alu import qce_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire alu_cmd_type  cmd,
   input  wire logic [63:0]  mag_a,
   input  wire logic [63:0]  mag_b,
   output alu_stat_type      stat,
   output logic [63:0]       mag_q
);
   // Multiply: shift-add over 64 multiplier bits into a 128-bit accumulator.
   // Divide: restoring division over 96 dividend bits, one bit a cycle.
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   alu_op_type   op_ff, op_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  b_ff, b_in;
   logic [95:0]  dvd_ff, dvd_in;
   logic [64:0]  rem_ff, rem_in;
   logic         ovf_ff, ovf_in;
   logic         done_ff, done_in;
   logic [64:0]  rem_sh, rem_sub;
   logic [6:0]   last_cnt;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[63:0], dvd_ff[95]};
      rem_sub = rem_sh - {1'b0, b_ff};
      last_cnt = (op_ff == ALU_MUL) ? 7'd63 : 7'd95;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         acc_in  = '0;
         b_in    = mag_b;
         dvd_in  = {mag_a, 32'd0};
         rem_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            // Multiplier bits are consumed most significant first.
            acc_in = {acc_ff[126:0], 1'b0} + (dvd_ff[95] ? {64'd0, b_ff} : 128'd0);
            dvd_in = {dvd_ff[94:0], 1'b0};
         end else begin
            if (acc_ff[63]) ovf_in = 1'b1;
            dvd_in = {dvd_ff[94:0], 1'b0};
            if (!rem_sub[64]) begin
               rem_in = rem_sub;
               acc_in = {64'd0, acc_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               acc_in = {64'd0, acc_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == last_cnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      ovf_ff <= ovf_in;
   end

   // For multiply the Q32.32 product keeps bits 95:32; anything above overflows.
   always_comb begin
      stat.done = done_ff;
      stat.busy = busy_ff;
      if (op_ff == ALU_MUL) begin
         mag_q    = acc_ff[95:32];
         stat.ovf = acc_ff[127:96] != 32'd0;
      end else begin
         mag_q    = acc_ff[63:0];
         stat.ovf = ovf_ff;
      end
   end

   `QCE_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start && !busy_ff, busy_ff)
   `QCE_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)
   `QCE_ASSERT_IMP(a_cnt_range, clock, reset, busy_ff, cnt_ff <= 7'd95)
endmodule
`default_nettype wire

@@ hw/rtl/qce_regfile.sv @@
// Variable and temporary register files with reset-valid bits.
// Depends on qce_pkg.
`default_nettype none
module qce_regfile import qce_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          rd_kind,
   input  wire logic [RegIdxW-1:0]  rd_index,
   output logic [63:0]              rd_data,
   input  wire logic                wr_en,
   input  wire logic [1:0]          wr_kind,
   input  wire logic [RegIdxW-1:0]  wr_index,
   input  wire logic [63:0]         wr_data
);
   // One read address per cycle; operands are fetched in turn.
   logic [63:0] var_mem [VariableCount];
   logic [63:0] tmp_mem [TemporaryCount];
   logic [VariableCount-1:0]  var_vld_ff;
   logic [TemporaryCount-1:0] tmp_vld_ff;
   logic [63:0] var_q, tmp_q;
   logic        var_ok_ff, tmp_ok_ff, sel_var_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_kind == KIND_VAR) var_mem[wr_index] <= wr_data;
      if (wr_en && wr_kind == KIND_TMP) tmp_mem[wr_index] <= wr_data;
      var_q <= var_mem[rd_index];
      tmp_q <= tmp_mem[rd_index];
      var_ok_ff  <= var_vld_ff[rd_index];
      tmp_ok_ff  <= tmp_vld_ff[rd_index];
      sel_var_ff <= rd_kind == KIND_VAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         var_vld_ff <= '0;
         tmp_vld_ff <= '0;
      end else if (wr_en) begin
         if (wr_kind == KIND_VAR) var_vld_ff[wr_index] <= 1'b1;
         if (wr_kind == KIND_TMP) tmp_vld_ff[wr_index] <= 1'b1;
      end
   end

   assign rd_data = sel_var_ff ? (var_ok_ff ? var_q : 64'd0)
                               : (tmp_ok_ff ? tmp_q : 64'd0);
endmodule
`default_nettype wire

@@ hw/rtl/quad_code_executor_top.sv @@
// Top level of the quad code executor: sequencer, operand fetch and result stage.
// Depends on qce_pkg, qce_regfile, qce_alu and the assertion macros header.
`default_nettype none
`include "quad_code_executor_top_defines.svh"
// One instruction beat is taken at a time. MOV, ADD, SUB, jumps and halted
// beats pass through the accepting idle state, two operand reads from the
// single read port, a capture state, one execute step and the result state.
// MUL and DIV with a nonzero divisor then wait for the shared unit: 64
// shift-add steps or 96 divider steps, then a registered done that hands
// back the result. The result sits in an output register and the next beat
// is taken only after it has been delivered. Register files clear by valid
// bits, so no pass is needed after reset.
module quad_code_executor_top import qce_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [10:0]  csr_program_length,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [3:0]   req_mode,
   input  wire logic [1:0]   req_first_kind,
   input  wire logic [5:0]   req_first_index,
   input  wire logic signed [63:0] req_first_literal,
   input  wire logic [1:0]   req_second_kind,
   input  wire logic [5:0]   req_second_index,
   input  wire logic signed [63:0] req_second_literal,
   input  wire logic [1:0]   req_dest_kind,
   input  wire logic [5:0]   req_dest_index,
   input  wire logic [9:0]   req_jump_target,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [10:0]       rsp_next_pc,
   output logic              rsp_write_done,
   output logic signed [63:0] rsp_write_value,
   output logic [2:0]        rsp_status
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDA   = 7'b0000010,
      S_RDB   = 7'b0000100,
      S_CAPB  = 7'b0001000,
      S_EXEC  = 7'b0010000,
      S_WAIT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic [10:0]  plen_ff, pc_ff, pc_in;
   logic [3:0]   mode_ff;
   logic [1:0]   ak_ff, bk_ff, dk_ff;
   logic [5:0]   ai_ff, bi_ff, di_ff;
   logic [63:0]  alit_ff, blit_ff, a_ff, a_in, b_ff, b_in;
   logic [9:0]   tgt_ff;
   logic [10:0]  npc_ff, npc_in;
   logic         wd_ff, wd_in;
   logic [63:0]  wv_ff, wv_in;
   logic [2:0]   st_ff, st_in;
   logic [1:0]   rd_kind;
   logic [5:0]   rd_index;
   logic [63:0]  rd_data;
   logic         wr_en;
   alu_cmd_type  alu_cmd;
   alu_stat_type alu_stat;
   logic [63:0]  alu_q, mag_a, mag_b;
   logic         neg, lt_ab, lt_ba, take, halted;
   logic [63:0]  sum, dif, val, sres;
   logic         ovf;
   logic [10:0]  pc_inc, end_pc;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_next_pc = npc_ff;
   assign rsp_write_done = wd_ff;
   assign rsp_write_value = wv_ff;
   assign rsp_status = st_ff;

   assign rd_kind  = (state_ff == S_RDA) ? ak_ff : bk_ff;
   assign rd_index = (state_ff == S_RDA) ? ai_ff : bi_ff;

   qce_regfile u_rf (
      .clock(clock), .reset(reset),
      .rd_kind(rd_kind), .rd_index(rd_index), .rd_data(rd_data),
      .wr_en(wr_en), .wr_kind(dk_ff), .wr_index(di_ff), .wr_data(wv_in)
   );

   assign mag_a = a_ff[63] ? (64'd0 - a_ff) : a_ff;
   assign mag_b = b_ff[63] ? (64'd0 - b_ff) : b_ff;
   assign neg   = a_ff[63] ^ b_ff[63];

   qce_alu u_alu (
      .clock(clock), .reset(reset), .cmd(alu_cmd),
      .mag_a(mag_a), .mag_b(mag_b), .stat(alu_stat), .mag_q(alu_q)
   );

   assign end_pc = (plen_ff < 11'(ProgramDepth)) ? plen_ff : 11'(ProgramDepth);
   assign halted = pc_ff >= end_pc;
   assign pc_inc = pc_ff + 11'd1;
   assign sum = a_ff + b_ff;
   assign dif = a_ff - b_ff;
   assign lt_ab = $signed(a_ff) < $signed(b_ff);
   assign lt_ba = $signed(b_ff) < $signed(a_ff);

   // Sign applied to an unsigned multiply or divide magnitude, with saturation.
   always_comb begin
      if (alu_stat.ovf || alu_q > (neg ? NEG_MIN : POS_MAX))
         sres = neg ? NEG_MIN : POS_MAX;
      else
         sres = neg ? (64'd0 - alu_q) : alu_q;
   end

   always_comb begin
      unique case (mode_ff)
         MODE_JEQ:  take = a_ff == b_ff;
         MODE_JNEQ: take = a_ff != b_ff;
         MODE_JGT:  take = lt_ba;
         MODE_JGTE: take = !lt_ab;
         MODE_JLT:  take = lt_ab;
         MODE_JLTE: take = !lt_ba;
         default:   take = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in  = pc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      npc_in = npc_ff;
      wd_in  = wd_ff;
      wv_in  = wv_ff;
      st_in  = st_ff;
      wr_en  = 1'b0;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = (mode_ff == MODE_MUL) ? ALU_MUL : ALU_DIV;
      val = 64'd0;
      ovf = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_RDA;
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            a_in = ak_ff[1] ? alit_ff : rd_data;
            state_in = S_CAPB;
         end
         S_CAPB: begin
            b_in = bk_ff[1] ? blit_ff : rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            wd_in = 1'b0;
            wv_in = 64'd0;
            st_in = ST_OK;
            npc_in = pc_inc;
            if (halted) begin
               npc_in = pc_ff;
               st_in = ST_HALTED;
               state_in = S_OUT;
            end else if (mode_ff == MODE_MUL ||
                         (mode_ff == MODE_DIV && b_ff != 64'd0)) begin
               alu_cmd.start = 1'b1;
               state_in = S_WAIT;
            end else begin
               state_in = S_OUT;
               pc_in = pc_inc;
               if (mode_ff <= MODE_DIV) begin
                  case (mode_ff)
                     MODE_MOV: val = a_ff;
                     MODE_ADD: begin
                        val = sum;
                        if (a_ff[63] == b_ff[63] && sum[63] != a_ff[63]) begin
                           ovf = 1'b1;
                           val = a_ff[63] ? NEG_MIN : POS_MAX;
                        end
                     end
                     MODE_SUB: begin
                        val = dif;
                        if (a_ff[63] != b_ff[63] && dif[63] != a_ff[63]) begin
                           ovf = 1'b1;
                           val = a_ff[63] ? NEG_MIN : POS_MAX;
                        end
                     end
                     default: begin
                        // Divide by zero saturates towards the sign of the dividend; a zero dividend gives zero.
                        st_in = ST_DIVZ;
                        val = (a_ff == 64'd0) ? 64'd0 : (a_ff[63] ? NEG_MIN : POS_MAX);
                     end
                  endcase
                  if (ovf) st_in = ST_OVF;
                  if (dk_ff[1]) begin
                     st_in = ST_LIT;
                  end else begin
                     wr_en = 1'b1;
                     wd_in = 1'b1;
                     wv_in = val;
                  end
               end else if (mode_ff <= MODE_J && take) begin
                  npc_in = {1'b0, tgt_ff};
                  pc_in  = {1'b0, tgt_ff};
               end
            end
         end
         S_WAIT: if (alu_stat.done) begin
            pc_in = pc_inc;
            state_in = S_OUT;
            if (alu_stat.ovf || alu_q > (neg ? NEG_MIN : POS_MAX)) st_in = ST_OVF;
            if (dk_ff[1]) begin
               st_in = ST_LIT;
            end else begin
               wr_en = 1'b1;
               wd_in = 1'b1;
               wv_in = sres;
            end
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         plen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (csr_valid && csr_ready) plen_ff <= csr_program_length;
      end
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         ak_ff <= req_first_kind;
         ai_ff <= req_first_index;
         alit_ff <= req_first_literal;
         bk_ff <= req_second_kind;
         bi_ff <= req_second_index;
         blit_ff <= req_second_literal;
         dk_ff <= req_dest_kind;
         di_ff <= req_dest_index;
         tgt_ff <= req_jump_target;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      npc_ff <= npc_in;
      wd_ff  <= wd_in;
      wv_ff  <= wv_in;
      st_ff  <= st_in;
   end

   `QCE_ASSERT_IMP(a_rdy_out, clock, reset, rsp_valid, !req_ready)
   `QCE_ASSERT_IMP(a_wd_value, clock, reset, rsp_valid && !rsp_write_done, rsp_write_value == 64'd0)
   `QCE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule
`default_nettype wire
